/* sv/irpd_pkg.sv */
package irpd_pkg;

    // operation codes of an input beat
    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam int THRESH_W    = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BIT_ONE   = 2'd0,
        CFG_FRAME_GAP = 2'd1
    } cfg_reg_t;

    localparam logic [THRESH_W-1:0] BIT_ONE_RESET   = 16'd1500;
    localparam logic [THRESH_W-1:0] FRAME_GAP_RESET = 16'd15000;

    // symbol store control from the decoder
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

/* sv/irpd_fifo.sv */
module irpd_fifo #(
    parameter int SYMBOL_BITS = 7,
    parameter int FIFO_DEPTH  = 7,
    parameter int CNT_W       = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  irpd_pkg::fifo_ctrl_t   ctrl,
    input  logic [SYMBOL_BITS-1:0] push_data,
    output logic [SYMBOL_BITS-1:0] head_data,
    output logic [CNT_W-1:0]       count,
    output logic [CNT_W-1:0]       count_next
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [SYMBOL_BITS-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic                   full;

    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_data  = mem[rd_ptr_reg];
    assign count      = count_reg;

    // pointer and count update; a push into a full store drops the oldest
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : PTR_W'(wr_ptr_reg + 1'b1);
            if (full)
            begin
                rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : PTR_W'(rd_ptr_reg + 1'b1);
            end
            else
            begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : PTR_W'(rd_ptr_reg + 1'b1);
            count_next  = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("symbol count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (count_reg != '0) && !ctrl.push)
        else $error("pop from empty store or pop with push");
`endif

endmodule

/* sv/ir_pulse_distance_receiver_fifo.sv */
// IR pulse-distance receiver with a symbol FIFO.
// Input channel (in_valid/in_ready): operation selects an edge beat, which
// carries the microsecond timestamp edge_time of a falling edge, or a read
// beat, which pops the oldest stored symbol.
// Output channel (out_valid/out_ready): one result beat per input beat, in
// order: read_data/read_valid for reads, symbol_stored for edges, and
// symbols_available after the step.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
// the bit-one threshold, 1 the frame-gap threshold; other indexes are ignored.
// A beat is held in the input register until it can advance; its result is
// then registered in the result register, where out_valid rises.
// One beat per cycle is sustained while out_ready is high; the limit is the
// combinational state update between the input and result registers.
// Reset clears the decoder state, the FIFO count and both thresholds to
// their defaults (1500 and 15000). When out_ready is low the result is held,
// the input register still takes one more beat, and in_ready then drops
// until the result is taken.
module ir_pulse_distance_receiver_fifo #(
    parameter int SYMBOL_BITS = 7,
    parameter int FIFO_DEPTH  = 7,
    parameter int TIME_BITS   = 32,
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [TIME_BITS-1:0]             edge_time,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [SYMBOL_BITS-1:0]           read_data,
    output logic                             read_valid,
    output logic [CNT_W-1:0]                 symbols_available,
    output logic                             symbol_stored,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [irpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [irpd_pkg::THRESH_W-1:0]    cfg_data
);

    localparam int BC_W = (SYMBOL_BITS > 1) ? $clog2(SYMBOL_BITS) : 1;

    // configuration
    logic [irpd_pkg::THRESH_W-1:0] bit_one_reg;
    logic [irpd_pkg::THRESH_W-1:0] frame_gap_reg;

    // input register
    logic                 in_vld_reg;
    logic                 op_reg;
    logic [TIME_BITS-1:0] edge_time_reg;

    // decoder state
    logic [TIME_BITS-1:0]   last_edge_reg;
    logic [TIME_BITS-1:0]   last_edge_next;
    logic                   header_reg;
    logic                   header_next;
    logic [BC_W-1:0]        bit_count_reg;
    logic [BC_W-1:0]        bit_count_next;
    logic [SYMBOL_BITS-1:0] shift_reg;
    logic [SYMBOL_BITS-1:0] shift_next;

    // result register
    logic                   out_vld_reg;
    logic [SYMBOL_BITS-1:0] read_data_reg;
    logic [SYMBOL_BITS-1:0] read_data_next;
    logic                   read_valid_reg;
    logic [CNT_W-1:0]       avail_reg;
    logic                   stored_reg;
    logic                   stored_next;

    logic                   advance;
    logic [TIME_BITS-1:0]   gap;
    logic                   gap_frame;
    logic                   gap_one;
    logic [SYMBOL_BITS:0]   shifted;
    irpd_pkg::fifo_ctrl_t   fifo_ctrl;
    logic [SYMBOL_BITS-1:0] head_data;
    logic [CNT_W-1:0]       fifo_count;
    logic [CNT_W-1:0]       fifo_count_next;

    // handshake
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || !out_vld_reg || out_ready;
    assign cfg_ready = 1'b1;

    // interval with wrap, threshold compares
    assign gap       = edge_time_reg - last_edge_reg;
    assign gap_frame = gap > TIME_BITS'(frame_gap_reg);
    assign gap_one   = gap > TIME_BITS'(bit_one_reg);
    assign shifted   = {shift_reg, gap_one};

    // edge decoding and FIFO control
    always_comb
    begin
        last_edge_next = last_edge_reg;
        header_next    = header_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        fifo_ctrl      = '0;
        stored_next    = 1'b0;
        read_data_next = '0;
        if (advance)
        begin
            if (op_reg == irpd_pkg::OP_EDGE)
            begin
                last_edge_next = edge_time_reg;
                if (gap_frame)
                begin
                    header_next = 1'b0;
                end
                else if (!header_reg)
                begin
                    header_next    = 1'b1;
                    bit_count_next = '0;
                    shift_next     = '0;
                end
                else if (bit_count_reg == BC_W'(SYMBOL_BITS - 1))
                begin
                    fifo_ctrl.push = 1'b1;
                    stored_next    = 1'b1;
                    bit_count_next = '0;
                    shift_next     = '0;
                end
                else
                begin
                    bit_count_next = BC_W'(bit_count_reg + 1'b1);
                    shift_next     = shifted[SYMBOL_BITS-1:0];
                end
            end
            else if (fifo_count != '0)
            begin
                fifo_ctrl.pop  = 1'b1;
                read_data_next = head_data;
            end
        end
    end

    irpd_fifo #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .FIFO_DEPTH  (FIFO_DEPTH),
        .CNT_W       (CNT_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fifo_ctrl),
        .push_data  (shifted[SYMBOL_BITS-1:0]),
        .head_data  (head_data),
        .count      (fifo_count),
        .count_next (fifo_count_next)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_one_reg   <= irpd_pkg::BIT_ONE_RESET;
            frame_gap_reg <= irpd_pkg::FRAME_GAP_RESET;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            last_edge_reg <= '0;
            header_reg    <= 1'b0;
            bit_count_reg <= '0;
            shift_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    irpd_pkg::CFG_BIT_ONE:   bit_one_reg   <= cfg_data;
                    irpd_pkg::CFG_FRAME_GAP: frame_gap_reg <= cfg_data;
                    default:                 ;
                endcase
            end
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            last_edge_reg <= last_edge_next;
            header_reg    <= header_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg        <= operation;
            edge_time_reg <= edge_time;
        end
        if (advance)
        begin
            read_data_reg  <= read_data_next;
            read_valid_reg <= fifo_ctrl.pop;
            avail_reg      <= fifo_count_next;
            stored_reg     <= stored_next;
        end
    end

    assign out_valid         = out_vld_reg;
    assign read_data         = read_data_reg;
    assign read_valid        = read_valid_reg;
    assign symbols_available = avail_reg;
    assign symbol_stored     = stored_reg;

`ifndef SYNTH
    a_read_or_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(read_valid_reg && stored_reg))
        else $error("result beat flags both a read and a stored symbol");

    a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !read_valid_reg) |-> (read_data_reg == '0))
        else $error("read data nonzero without a stored symbol");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_vld_reg && out_vld_reg && !out_ready))
        else $error("input stalled while a stage is free");
`endif

endmodule
